// File: rtl/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg: shared types and helpers for the converter result capture block
// Operation, channel and register codes, buffer geometry and the small
// arithmetic helpers used by the capture datapath.
// ----------------------------------------------------------------------------
package acr_pkg;

  // capture buffer geometry
  localparam int BUF_DEPTH = 64;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int LEN_W     = BUF_AW + 1;
  // step counter of the wrap slot unit, one step per bit of LEN_W
  localparam int DIV_CNT_W = $clog2(LEN_W);

  localparam logic [13:0] VOLT_GAIN    = 14'd57;
  localparam logic [7:0]  MIC_CLIP     = 8'd230;
  localparam logic [6:0]  CAP_LEN_RST  = 7'd64;
  localparam int          METER_BITS   = 5;
  localparam logic [4:0]  METER_START  = 5'b00010;

  localparam logic [7:0] METER_THRESH [METER_BITS] = '{8'd4, 8'd8, 8'd16, 8'd32, 8'd64};

  typedef enum logic [1:0] {
    OP_CONV  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CH_DIST = 2'd0,
    CH_VOLT = 2'd1,
    CH_MIC  = 2'd2,
    CH_NONE = 2'd3
  } chan_e;

  typedef enum logic [1:0] {
    REG_TRIG_LEVEL   = 2'd0,
    REG_TRIG_TIMEOUT = 2'd1,
    REG_SINGLE_SHOT  = 2'd2,
    REG_CAP_LEN      = 2'd3
  } cfg_reg_e;

  function automatic logic [METER_BITS-1:0] thermometer(input logic [7:0] level);
    logic [METER_BITS-1:0] bits;
    bits = '0;
    for (int i = 0; i < METER_BITS; i++) begin
      bits[i] = (level > METER_THRESH[i]);
    end
    return bits;
  endfunction

  // length register clamped to 1 .. BUF_DEPTH
  function automatic logic [LEN_W-1:0] eff_len(input logic [6:0] cap_len);
    logic [LEN_W-1:0] len;
    if (cap_len == 7'd0) begin
      len = LEN_W'(1);
    end else if ({25'd0, cap_len} > 32'(BUF_DEPTH)) begin
      len = LEN_W'(BUF_DEPTH);
    end else begin
      len = LEN_W'(cap_len);
    end
    return len;
  endfunction

endpackage

// File: rtl/adc_result_capture_trigger.sv
// ----------------------------------------------------------------------------
// adc_result_capture_trigger: converter result latch, level meter and capture
// Latches distance and scaled voltage results, clips microphone results into
// a level meter and a circular capture buffer with trigger or averaging.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (operation, channel, sample, read_index) enter on in_valid_i
//   and are taken at an edge where in_stall_o is low. Every word yields one
//   result word on out_valid_o, taken when out_stall_i is low.
//   A word passes the input register, where the buffer reads for that word
//   land, and then the result register. One word per cycle is sustained
//   while out_stall_i is low; the buffer read-modify-write of the current
//   slot and the read port for operation 3 both come from a two-read-port
//   RAM, with write forwarding for back-to-back words on the same slot.
//   When out_stall_i holds, the result stays and the input register still
//   takes one more word; after that in_stall_o rises.
//   Configuration words go on cfg_valid_i / cfg_index_i / cfg_data_i and
//   must only be written while the block is idle. After a capture_length
//   write, cfg_ready_o and the input stall while the wrap slot for a write
//   slot beyond the new length is worked out one bit per cycle. Reset
//   initialises the control state; the buffer reads as zero until each
//   slot is written (a valid bit per slot), so no clearing pass is needed.
// ----------------------------------------------------------------------------
module adc_result_capture_trigger (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  channel_i,
  input  logic [7:0]  sample_i,
  input  logic [5:0]  read_index_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  distance_raw_o,
  output logic [13:0] voltage_scaled_o,
  output logic [7:0]  mic_sample_o,
  output logic [4:0]  level_meter_o,
  output logic        capturing_o,
  output logic [5:0]  fill_index_o,
  output logic [7:0]  read_value_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  import acr_pkg::*;

  // configuration registers
  logic [7:0]  trig_level_q;
  logic [15:0] trig_timeout_q;
  logic        single_shot_q;
  logic [6:0]  cap_len_q;

  // input register
  logic        s1_valid_q;
  logic [1:0]  s1_op_q;
  logic [1:0]  s1_chan_q;
  logic [7:0]  s1_sample_q;
  logic [5:0]  s1_ridx_q;

  // block state, shown directly as the result
  logic                  res_valid_q;
  logic [BUF_AW-1:0]     slot_q, slot_d;
  logic [15:0]           tmo_q, tmo_d;
  logic                  armed_q, armed_d;
  logic                  active_q, active_d;
  logic [METER_BITS-1:0] meter_q, meter_d;
  logic [7:0]            dist_q, dist_d;
  logic [13:0]           volt_q, volt_d;
  logic [7:0]            mic_q, mic_d;
  logic [7:0]            rval_q, rval_d;

  // buffer ports and forwarding
  logic [BUF_DEPTH-1:0]  slot_valid_q;
  logic                  we;
  logic [BUF_AW-1:0]     waddr;
  logic [7:0]            wdata;
  logic [BUF_AW-1:0]     raddr_a;
  logic [7:0]            ram_a, ram_b;
  logic [7:0]            wdata_q;
  logic                  byp_a_q, byp_b_q;
  logic                  vld_a_q, vld_b_q;
  logic [7:0]            rd_a, rd_b;

  // wrap slot unit: (slot + 1) mod length, run after a length write
  logic                  len_wr;
  logic                  div_busy_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;
  logic [LEN_W-1:0]      div_num_q;
  logic [LEN_W-1:0]      div_rem_q;
  logic [LEN_W:0]        div_step;
  logic [LEN_W:0]        div_sub;
  logic [LEN_W-1:0]      div_rem_d;

  logic                  proc, accept;
  logic [7:0]            mic_clip;
  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      slot_inc;
  logic                  past_len;
  logic                  triggered;
  logic                  rd_in_range;
  logic [8:0]            avg_sum;

  assign proc        = s1_valid_q && !div_busy_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o  = div_busy_q || (s1_valid_q && !proc);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !div_busy_q;
  assign len_wr      = cfg_valid_i && cfg_ready_o && (cfg_reg_e'(cfg_index_i) == REG_CAP_LEN);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_level_q   <= '0;
      trig_timeout_q <= '0;
      single_shot_q  <= 1'b0;
      cap_len_q      <= CAP_LEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TRIG_LEVEL:   trig_level_q   <= cfg_data_i[7:0];
        REG_TRIG_TIMEOUT: trig_timeout_q <= cfg_data_i;
        REG_SINGLE_SHOT:  single_shot_q  <= cfg_data_i[0];
        REG_CAP_LEN:      cap_len_q      <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ wrap slot
  // restoring remainder, one numerator bit per cycle, msb first
  assign div_step  = {div_rem_q, div_num_q[LEN_W-1]};
  assign div_sub   = div_step - {1'b0, len};
  assign div_rem_d = (div_step >= {1'b0, len}) ? div_sub[LEN_W-1:0] : div_step[LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      div_num_q  <= '0;
      div_rem_q  <= '0;
    end else if (len_wr) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= DIV_CNT_W'(LEN_W - 1);
      div_num_q  <= {1'b0, slot_q} + LEN_W'(1);
      div_rem_q  <= '0;
    end else if (div_busy_q) begin
      div_num_q <= {div_num_q[LEN_W-2:0], 1'b0};
      div_rem_q <= div_rem_d;
      if (div_cnt_q == '0) begin
        div_busy_q <= 1'b0;
      end else begin
        div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------- input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (proc) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q     <= operation_i;
      s1_chan_q   <= channel_i;
      s1_sample_q <= sample_i;
      s1_ridx_q   <= read_index_i;
    end
  end

  // ---------------------------------------------------------------- buffer
  // port a follows the word in the input register, port b the next slot
  assign raddr_a = accept ? BUF_AW'(read_index_i) : BUF_AW'(s1_ridx_q);

  acr_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (ram_a),
    .raddr_b_i (slot_d),
    .rdata_b_o (ram_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      byp_a_q      <= 1'b0;
      byp_b_q      <= 1'b0;
      vld_a_q      <= 1'b0;
      vld_b_q      <= 1'b0;
    end else begin
      if (we) begin
        slot_valid_q[waddr] <= 1'b1;
      end
      byp_a_q <= we && (waddr == raddr_a);
      byp_b_q <= we && (waddr == slot_d);
      vld_a_q <= slot_valid_q[raddr_a];
      vld_b_q <= slot_valid_q[slot_d];
    end
  end

  always_ff @(posedge clk_i) begin
    wdata_q <= wdata;
  end

  // a slot never written reads as zero
  assign rd_a = byp_a_q ? wdata_q : (vld_a_q ? ram_a : 8'd0);
  assign rd_b = byp_b_q ? wdata_q : (vld_b_q ? ram_b : 8'd0);

  // ------------------------------------------------------------- datapath
  assign mic_clip    = (s1_sample_q < MIC_CLIP) ? s1_sample_q : 8'd0;
  assign len         = eff_len(cap_len_q);
  assign slot_inc    = {1'b0, slot_q} + LEN_W'(1);
  // only after the length shrank under a capture, until the next write
  assign past_len    = ({1'b0, slot_q} >= len);
  assign triggered   = (trig_level_q != 8'd0);
  assign rd_in_range = ({26'd0, s1_ridx_q} < 32'(BUF_DEPTH));
  assign avg_sum     = {1'b0, rd_b} + {1'b0, mic_clip};

  always_comb begin
    slot_d   = slot_q;
    tmo_d    = tmo_q;
    armed_d  = armed_q;
    active_d = active_q;
    meter_d  = meter_q;
    dist_d   = dist_q;
    volt_d   = volt_q;
    mic_d    = mic_q;
    rval_d   = 8'd0;
    we       = 1'b0;
    waddr    = slot_q;
    wdata    = triggered ? mic_clip : avg_sum[8:1];
    if (proc) begin
      case (op_e'(s1_op_q))
        OP_CONV: begin
          case (chan_e'(s1_chan_q))
            CH_DIST: dist_d = s1_sample_q;
            CH_VOLT: volt_d = 14'(s1_sample_q) * VOLT_GAIN;
            CH_MIC: begin
              mic_d   = mic_clip;
              meter_d = thermometer(mic_clip);
              if (active_q) begin
                if (slot_q == '0 && triggered && mic_clip <= trig_level_q) begin
                  // still waiting for the trigger
                  tmo_d = tmo_q - 16'd1;
                  if (tmo_d == 16'd0) begin
                    armed_d  = 1'b0;
                    active_d = 1'b0;
                  end
                end else begin
                  we = 1'b1;
                  if ({1'b0, slot_q} == len - LEN_W'(1) && armed_q) begin
                    armed_d  = 1'b0;
                    active_d = 1'b0;
                  end
                  if (past_len) begin
                    slot_d = BUF_AW'(div_rem_q);
                  end else if (slot_inc == len) begin
                    slot_d = '0;
                  end else begin
                    slot_d = BUF_AW'(slot_inc);
                  end
                end
              end
            end
            default: ;
          endcase
        end
        OP_START: begin
          slot_d   = '0;
          tmo_d    = trig_timeout_q;
          armed_d  = single_shot_q;
          active_d = 1'b1;
          meter_d  = meter_q | METER_START;
        end
        OP_STOP: begin
          active_d = 1'b0;
          meter_d  = '0;
        end
        OP_READ: rval_d = rd_in_range ? rd_a : 8'd0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      slot_q      <= '0;
      tmo_q       <= '0;
      armed_q     <= 1'b0;
      active_q    <= 1'b0;
      meter_q     <= '0;
      dist_q      <= '0;
      volt_q      <= '0;
      mic_q       <= '0;
      rval_q      <= '0;
    end else begin
      if (proc) begin
        res_valid_q <= 1'b1;
        rval_q      <= rval_d;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
      slot_q   <= slot_d;
      tmo_q    <= tmo_d;
      armed_q  <= armed_d;
      active_q <= active_d;
      meter_q  <= meter_d;
      dist_q   <= dist_d;
      volt_q   <= volt_d;
      mic_q    <= mic_d;
    end
  end

  // state only moves when a word enters the result register
  assign out_valid_o      = res_valid_q;
  assign distance_raw_o   = dist_q;
  assign voltage_scaled_o = volt_q;
  assign mic_sample_o     = mic_q;
  assign level_meter_o    = meter_q;
  assign capturing_o      = active_q;
  assign fill_index_o     = 6'(slot_q);
  assign read_value_o     = rval_q;

endmodule

// File: rtl/acr_ram.sv
// ----------------------------------------------------------------------------
// acr_ram: generic RAM, one write port and two registered read ports
// Read data shows the contents before a write in the same cycle.
// ----------------------------------------------------------------------------
module acr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: test/tb_adc_result_capture_trigger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_result_capture_trigger: testbench for the converter result capture
// Directed tests cover the latches, clipping, the level meter, triggered and
// free-run capture, the timeout and the length handling. Random capture
// sequences follow under random idling and back-pressure. Every result word
// is checked against a cycle-free model of the block kept in the bench.
// ----------------------------------------------------------------------------
module tb_adc_result_capture_trigger;
  import acr_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RST_CYCLES    = 12;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_WORDS  = 1750;
  localparam int PHASES        = 14;
  localparam int VOLT_FACTOR   = 57;
  localparam int CLIP_AT       = 230;

  typedef struct packed {
    logic [7:0]  distance;
    logic [13:0] voltage;
    logic [7:0]  mic;
    logic [4:0]  meter;
    logic        capturing;
    logic [5:0]  fill;
    logic [7:0]  read_value;
  } capture_word_t;

  typedef enum int {RX_READY, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  op_e         in_op = OP_CONV;
  chan_e       in_chan = CH_DIST;
  logic [7:0]  in_sample = '0;
  logic [5:0]  in_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  distance_raw;
  logic [13:0] voltage_scaled;
  logic [7:0]  mic_value;
  logic [4:0]  level_meter;
  logic        capturing;
  logic [5:0]  fill_index;
  logic [7:0]  read_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_reg_e    cfg_index = REG_TRIG_LEVEL;
  logic [15:0] cfg_data = '0;

  // bench copy of the block state and registers
  logic [7:0]  shadow_buf [BUF_DEPTH] = '{default: 8'd0};
  logic [5:0]  shadow_slot = '0;
  logic [15:0] shadow_countdown = '0;
  logic        shadow_armed = 1'b0;
  logic        shadow_active = 1'b0;
  logic [4:0]  shadow_meter = '0;
  logic [7:0]  shadow_distance = '0;
  logic [13:0] shadow_voltage = '0;
  logic [7:0]  shadow_mic = '0;
  logic [7:0]  set_level = '0;
  logic [15:0] set_timeout = '0;
  logic        set_one_shot = 1'b0;
  logic [6:0]  set_length = 7'd64;

  capture_word_t expected_words [$];

  int       cycle_count = 0;
  int       words_sent = 0;
  int       results_checked = 0;
  int       mismatches = 0;
  int       cfg_writes = 0;
  int       starts = 0;
  int       slots_written = 0;
  int       expiries = 0;
  int       one_shot_stops = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b0;
  bit       hold_request = 1'b0;
  rx_mode_e rx_mode = RX_READY;

  adc_result_capture_trigger i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .operation_i      (in_op),
    .channel_i        (in_chan),
    .sample_i         (in_sample),
    .read_index_i     (in_index),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .distance_raw_o   (distance_raw),
    .voltage_scaled_o (voltage_scaled),
    .mic_sample_o     (mic_value),
    .level_meter_o    (level_meter),
    .capturing_o      (capturing),
    .fill_index_o     (fill_index),
    .read_value_o     (read_value),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // capture model
  // ---------------------------------------------------------------------------
  function automatic logic [4:0] meter_of(input logic [7:0] lvl);
    return {lvl > 8'd64, lvl > 8'd32, lvl > 8'd16, lvl > 8'd8, lvl > 8'd4};
  endfunction

  function automatic int clamped_length();
    int len;
    len = int'(set_length);
    if (len == 0) begin
      len = 1;
    end else if (len > BUF_DEPTH) begin
      len = BUF_DEPTH;
    end
    return len;
  endfunction

  function automatic void store_mic(input logic [7:0] mic);
    int         len;
    int         slot;
    logic [8:0] sum;
    len  = clamped_length();
    slot = int'(shadow_slot);
    // first slot holds off until the level is crossed
    if (slot == 0 && set_level != 8'd0 && mic <= set_level) begin
      shadow_countdown = shadow_countdown - 16'd1;
      if (shadow_countdown == 16'd0) begin
        shadow_armed  = 1'b0;
        shadow_active = 1'b0;
        expiries++;
      end
      return;
    end
    if (set_level != 8'd0) begin
      shadow_buf[slot] = mic;
    end else begin
      sum = {1'b0, shadow_buf[slot]} + {1'b0, mic};
      shadow_buf[slot] = sum[8:1];
    end
    slots_written++;
    if (slot == len - 1 && shadow_armed) begin
      shadow_armed  = 1'b0;
      shadow_active = 1'b0;
      one_shot_stops++;
    end
    shadow_slot = 6'((slot + 1) % len);
  endfunction

  function automatic capture_word_t predict_result(input op_e op, input chan_e ch,
                                                   input logic [7:0] smp,
                                                   input logic [5:0] idx);
    capture_word_t res;
    logic [7:0]    clipped;
    res = '0;
    case (op)
      OP_CONV: begin
        case (ch)
          CH_DIST: shadow_distance = smp;
          CH_VOLT: shadow_voltage = 14'(int'(smp) * VOLT_FACTOR);
          CH_MIC: begin
            clipped = (int'(smp) < CLIP_AT) ? smp : 8'd0;
            shadow_mic   = clipped;
            shadow_meter = meter_of(clipped);
            if (shadow_active) store_mic(clipped);
          end
          CH_NONE: ;
        endcase
      end
      OP_START: begin
        shadow_slot      = '0;
        shadow_countdown = set_timeout;
        shadow_armed     = set_one_shot;
        shadow_active    = 1'b1;
        shadow_meter[1]  = 1'b1;
        starts++;
      end
      OP_STOP: begin
        shadow_active = 1'b0;
        shadow_meter  = '0;
      end
      OP_READ: res.read_value = shadow_buf[idx];
    endcase
    res.distance  = shadow_distance;
    res.voltage   = shadow_voltage;
    res.mic       = shadow_mic;
    res.meter     = shadow_meter;
    res.capturing = shadow_active;
    res.fill      = shadow_slot;
    return res;
  endfunction

  function automatic string fmt_word(input capture_word_t w);
    return $sformatf("dist %0d volt %0d mic %0d meter %b cap %b fill %0d read %0d",
                     w.distance, w.voltage, w.mic, w.meter, w.capturing, w.fill,
                     w.read_value);
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int k;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        case (rx_mode)
          RX_READY:    out_stall <= 1'b0;
          RX_RANDOM:   out_stall <= ($urandom_range(0, 99) < 25);
          RX_PERIODIC: out_stall <= ((cycle_count % 7) < 3);
          default:     out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_result
    capture_word_t seen;
    capture_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = {distance_raw, voltage_scaled, mic_value, level_meter, capturing,
              fill_index, read_value};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result word: %s", fmt_word(seen));
      end else begin
        want = expected_words.pop_front();
        results_checked++;
        if (seen.distance !== want.distance || seen.voltage !== want.voltage ||
            seen.mic !== want.mic || seen.meter !== want.meter ||
            seen.capturing !== want.capturing || seen.fill !== want.fill ||
            seen.read_value !== want.read_value) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch on result %0d", results_checked);
            $display("  expected %s", fmt_word(want));
            $display("  actual   %s", fmt_word(seen));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_word(input op_e op, input chan_e ch, input logic [7:0] smp,
                           input logic [5:0] idx);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left--;
    end
    in_op     <= op;
    in_chan   <= ch;
    in_sample <= smp;
    in_index  <= idx;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(predict_result(op, ch, smp, idx));
    words_sent++;
  endtask

  task automatic send_mic(input logic [7:0] smp);
    send_word(OP_CONV, CH_MIC, smp, 6'($urandom));
  endtask

  task automatic send_random_word();
    send_word(op_e'($urandom_range(0, 3)), chan_e'($urandom_range(0, 3)), 8'($urandom),
              6'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with no words in flight
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TRIG_LEVEL:   set_level = data[7:0];
      REG_TRIG_TIMEOUT: set_timeout = data;
      REG_SINGLE_SHOT:  set_one_shot = data[0];
      REG_CAP_LEN:      set_length = data[6:0];
    endcase
    cfg_writes++;
  endtask

  task automatic write_all(input logic [7:0] lvl, input logic [15:0] tmo, input logic one,
                           input logic [6:0] len);
    write_reg(REG_TRIG_LEVEL, {8'd0, lvl});
    write_reg(REG_TRIG_TIMEOUT, tmo);
    write_reg(REG_SINGLE_SHOT, {15'd0, one});
    write_reg(REG_CAP_LEN, {9'd0, len});
  endtask

  function automatic logic [7:0] pick_mic();
    int roll;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      v = int'(set_level) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
    end
    if (roll < 55) return 8'($urandom_range(230, 255));
    return 8'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_latches();
    rx_mode = RX_RANDOM;
    gaps_on = 1'b1;
    send_word(OP_CONV, CH_DIST, 8'd0, 6'd0);
    send_word(OP_CONV, CH_DIST, 8'd255, 6'd63);
    send_word(OP_CONV, CH_VOLT, 8'd255, 6'd0);
    send_word(OP_CONV, CH_VOLT, 8'd1, 6'd0);
    // unknown channel leaves every latch alone
    send_word(OP_CONV, CH_NONE, 8'hAA, 6'd21);
    send_mic(8'd229);
    send_mic(8'd230);
    send_mic(8'd255);
    send_mic(8'd4);
    send_mic(8'd5);
    send_mic(8'd64);
    send_mic(8'd65);
    send_word(OP_READ, CH_MIC, 8'hFF, 6'd63);
    send_word(OP_READ, CH_DIST, 8'd0, 6'd0);
    wait_idle();
  endtask

  task automatic test_free_run();
    rx_mode = RX_PERIODIC;
    write_all(8'd0, 16'd5, 1'b0, 7'd3);
    send_word(OP_START, CH_DIST, 8'd0, 6'd0);
    send_mic(8'd200);
    send_mic(8'd100);
    send_mic(8'd50);
    send_mic(8'd229);
    send_word(OP_STOP, CH_DIST, 8'd0, 6'd0);
    send_word(OP_READ, CH_DIST, 8'd0, 6'd0);
    send_word(OP_READ, CH_DIST, 8'd0, 6'd2);
    wait_idle();
    // zero length acts as one slot, single shot ends at once
    write_reg(REG_SINGLE_SHOT, 16'd1);
    write_reg(REG_CAP_LEN, 16'd0);
    send_word(OP_START, CH_VOLT, 8'd9, 6'd5);
    send_mic(8'd40);
    send_mic(8'd40);
    send_word(OP_READ, CH_DIST, 8'd0, 6'd0);
    wait_idle();
  endtask

  task automatic test_trigger();
    rx_mode = RX_HEAVY;
    write_all(8'd100, 16'd3, 1'b1, 7'd4);
    send_word(OP_START, CH_MIC, 8'd0, 6'd0);
    send_mic(8'd100);
    send_mic(8'd50);
    send_mic(8'd101);
    send_mic(8'd10);
    send_mic(8'd20);
    send_mic(8'd30);
    send_mic(8'd150);
    wait_idle();
    // expiry on the second untriggered sample
    write_reg(REG_TRIG_TIMEOUT, 16'd2);
    send_word(OP_START, CH_MIC, 8'd0, 6'd0);
    send_mic(8'd0);
    send_mic(8'd100);
    wait_idle();
    // zero timeout wraps and keeps waiting
    write_reg(REG_TRIG_TIMEOUT, 16'd0);
    send_word(OP_START, CH_MIC, 8'd0, 6'd0);
    repeat (4) send_mic(8'd1);
    send_word(OP_STOP, CH_MIC, 8'd0, 6'd0);
    wait_idle();
  endtask

  task automatic test_length_change();
    rx_mode = RX_RANDOM;
    write_all(8'd0, 16'd0, 1'b0, 7'd127);
    send_word(OP_START, CH_DIST, 8'd0, 6'd0);
    repeat (3) send_mic(8'($urandom_range(0, 229)));
    wait_idle();
    // shrink under an active capture: slot 3 is still written, then wrap mod 2
    write_reg(REG_CAP_LEN, 16'd2);
    repeat (3) send_mic(8'($urandom_range(0, 229)));
    send_word(OP_STOP, CH_DIST, 8'd0, 6'd0);
    send_word(OP_READ, CH_DIST, 8'd0, 6'd3);
    wait_idle();
    write_reg(REG_CAP_LEN, 16'd64);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    rx_mode = RX_READY;
    hold_request = 1'b1;
    send_word(OP_START, CH_DIST, 8'd0, 6'd0);
    repeat (40) begin
      if ($urandom_range(0, 1) == 1) send_mic(pick_mic());
      else send_random_word();
    end
    wait_idle();
  endtask

  task automatic test_random();
    int          p;
    int          k;
    int          n;
    int          roll;
    int          quota;
    logic [7:0]  lvl;
    logic [15:0] tmo;
    logic [6:0]  len;
    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       lvl = 8'd0;
        1:       lvl = 8'd255;
        2:       lvl = 8'($urandom_range(1, 40));
        default: lvl = 8'($urandom_range(1, 254));
      endcase
      case (p % 5)
        0:       tmo = 16'd0;
        1:       tmo = 16'd1;
        2:       tmo = 16'hFFFF;
        3:       tmo = 16'($urandom_range(2, 24));
        default: tmo = 16'($urandom);
      endcase
      case (p % 7)
        0:       len = 7'd0;
        1:       len = 7'd1;
        2:       len = 7'd2;
        3:       len = 7'd64;
        4:       len = 7'd127;
        5:       len = 7'($urandom_range(1, 16));
        default: len = 7'($urandom_range(3, 63));
      endcase
      write_all(lvl, tmo, 1'($urandom_range(0, 1)), len);
      rx_mode    = rx_mode_e'(p % 4);
      gaps_on    = (p % 3 != 0);
      burst_left = 0;
      quota      = words_sent + RANDOM_WORDS / PHASES;
      while (words_sent < quota) begin
        if ($urandom_range(0, 99) < 85) begin
          send_word(OP_START, chan_e'($urandom_range(0, 3)), 8'($urandom), 6'($urandom));
          n = $urandom_range(1, 2 * clamped_length() + 6);
          for (k = 0; k < n && words_sent < quota; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) send_mic(pick_mic());
            else if (roll < 88) send_word(OP_CONV, chan_e'($urandom_range(0, 3)),
                                          8'($urandom), 6'($urandom));
            else send_word(OP_READ, chan_e'($urandom_range(0, 3)), 8'($urandom),
                           6'($urandom));
          end
          if ($urandom_range(0, 99) < 70) send_word(OP_STOP, CH_MIC, 8'($urandom), 6'($urandom));
          repeat ($urandom_range(0, 4)) send_word(OP_READ, CH_DIST, 8'($urandom), 6'($urandom));
        end else begin
          repeat ($urandom_range(1, 6)) send_random_word();
        end
      end
      wait_idle();
    end
  endtask

  initial begin : main
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_latches();
    test_free_run();
    test_trigger();
    test_length_change();
    test_backpressure();
    test_random();
    $display("sent %0d words, checked %0d results, %0d register writes",
             words_sent, results_checked, cfg_writes);
    $display("captures %0d, slots written %0d, timeout expiries %0d, single-shot ends %0d",
             starts, slots_written, expiries, one_shot_stops);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/acr_pkg.sv
rtl/acr_ram.sv
rtl/adc_result_capture_trigger.sv
test/tb_adc_result_capture_trigger.sv
